### hw/rtl/kwm_pkg.sv
// Shared constants and types for the k-way sorted merge unit.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  // Width of the stream-count register.
  localparam int CFG_W = 5;

  // Width of the stream index field on the result channel.
  localparam int SRC_FIELD_W = 4;

  typedef logic [CFG_W-1:0]       cfg_t;
  typedef logic [SRC_FIELD_W-1:0] src_field_t;

endpackage : kwm_pkg

`default_nettype wire

### hw/rtl/kwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule : kwm_ram

`default_nettype wire

### hw/rtl/kwm_cmp.sv
// Heap key comparator: signed value first, then the lower stream index wins a tie.
`timescale 1ns / 1ps
`default_nettype none

module kwm_cmp #(
  parameter int DW = 32,
  parameter int SW = 4
) (
  input  wire logic [DW-1:0] a_val,
  input  wire logic [SW-1:0] a_src,
  input  wire logic [DW-1:0] b_val,
  input  wire logic [SW-1:0] b_src,
  output logic               a_lt_b
);

  logic val_lt;
  logic val_eq;

  assign val_lt = $signed(a_val) < $signed(b_val);
  assign val_eq = a_val == b_val;
  assign a_lt_b = val_lt || (val_eq && (a_src < b_src));

endmodule : kwm_cmp

`default_nettype wire

### hw/rtl/k_way_sorted_merge_unit.sv
// Top level of the k-way sorted merge unit: sequencer, heap storage and result register.
//
// Usage. The unit merges up to MAX_LISTS ascending signed streams into one
// ascending stream. Write the stream count through cfg_wr_en/cfg_wr_data while
// the unit is idle. Then transfer one head per stream on the in_ channel
// (stream 0 first); in_tuser high marks a stream that is empty. The transfer
// that completes loading yields the first result: the smallest head in
// out_tdata with its stream index. Each following input transfer must carry
// the next element of that stream, or in_tuser high if the stream has ended.
// When every stream is exhausted, a result with out_tuser high and zero data
// is sent and the unit goes back to loading heads.
// Sequencing. One shared comparator and one heap RAM do all of the work; no
// input is taken until the current item is done. A head load writes its entry
// at the bottom and lets it climb, one parent compare per level. A refill sinks
// the root, comparing children per level; a stream end first fetches the last entry.
// Reset (rst_n low, synchronous) empties the heap, selects one stream and
// returns to loading. A finished result waits in the output register while
// the next input is taken; if the receiver stalls, the sequencer holds at
// the end of that next item until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module k_way_sorted_merge_unit #(
  parameter int MAX_LISTS  = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((DATA_WIDTH + kwm_pkg::SRC_FIELD_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration: stream count.
  input  wire logic                   cfg_wr_en,
  input  wire logic [kwm_pkg::CFG_W-1:0] cfg_wr_data,
  // Input channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // value
  input  wire logic                   in_tuser,   // list_ended
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // value_res, source_list
  output logic                        out_tuser   // done_res
);

  // Index into the heap, count of entries, and child-index arithmetic widths.
  localparam int IW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int CW = $clog2(MAX_LISTS + 1);
  localparam int XW = IW + 2;
  localparam int EW = (CW + 1 > kwm_pkg::CFG_W) ? CW + 1 : kwm_pkg::CFG_W;
  localparam int DW = DATA_WIDTH;
  localparam int SRC_W = kwm_pkg::SRC_FIELD_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SU_RD   = 3'd1;  // sift up: fetch parent
  localparam logic [2:0] ST_SU_CMP  = 3'd2;  // sift up: compare with parent
  localparam logic [2:0] ST_RD_LAST = 3'd3;  // fetch last entry to move to root
  localparam logic [2:0] ST_SD_L    = 3'd4;  // sift down: fetch left child
  localparam logic [2:0] ST_SD_R    = 3'd5;  // sift down: compare left, fetch right
  localparam logic [2:0] ST_SD_CMP  = 3'd6;  // sift down: compare right
  localparam logic [2:0] ST_FINISH  = 3'd7;  // present the result

  logic [2:0]    state_r, state_nxt;
  logic          phase_r, phase_nxt;        // 0 loading heads, 1 merging
  logic [CW-1:0] count_r, count_nxt;        // entries in the heap
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;  // heads taken so far
  logic          emit_r, emit_nxt;          // current item produces a result
  kwm_pkg::cfg_t num_lists_r;

  // The entry being placed and the hole it is moving through.
  logic [IW-1:0] hole_r, hole_nxt;
  logic [DW-1:0] cur_val_r, cur_val_nxt;
  logic [IW-1:0] cur_src_r, cur_src_nxt;

  // Smaller of the left child and the moving entry during sift down.
  logic [DW-1:0] best_val_r, best_val_nxt;
  logic [IW-1:0] best_src_r, best_src_nxt;
  logic          best_child_r, best_child_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;

  // Copy of the heap root.
  logic [DW-1:0] top_val_r, top_val_nxt;
  logic [IW-1:0] top_src_r, top_src_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [DW-1:0]    out_val_r, out_val_nxt;
  logic [SRC_W-1:0] out_src_r, out_src_nxt;
  logic             out_done_r, out_done_nxt;

  // RAM and comparator hookup.
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [DW+IW-1:0] ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [DW+IW-1:0] ram_rdata_r;
  logic [DW-1:0]    rd_val;
  logic [IW-1:0]    rd_src;
  logic [DW-1:0]    cmp_a_val, cmp_b_val;
  logic [IW-1:0]    cmp_a_src, cmp_b_src;
  logic             cmp_lt;

  // Sift-down decision inputs.
  logic          dec_en;
  logic          dec_child;
  logic [DW-1:0] dec_val;
  logic [IW-1:0] dec_src;
  logic [IW-1:0] dec_idx;

  logic              in_fire;
  logic [DW-1:0]     in_val;
  logic [XW-1:0]     hole_x, lchild, rchild, cnt_x;
  logic [IW-1:0]     parent;
  logic [EW-1:0]     eff, lc_inc;
  logic [CW-1:0]     cnt_dec;
  logic [IW+SRC_W-1:0] top_src_wide;

  assign in_val  = in_tdata[DW-1:0];
  assign in_fire = in_tvalid && in_tready;

  assign rd_val = ram_rdata_r[DW+IW-1:IW];
  assign rd_src = ram_rdata_r[IW-1:0];

  assign hole_x  = XW'(hole_r);
  assign lchild  = (hole_x << 1) + XW'(1);
  assign rchild  = lchild + XW'(1);
  assign cnt_x   = XW'(count_r);
  assign parent  = (hole_r - IW'(1)) >> 1;
  assign cnt_dec = count_r - CW'(1);

  assign top_src_wide = {{SRC_W{1'b0}}, top_src_r};

  // Effective stream count: zero counts as one, and it is capped at MAX_LISTS.
  always_comb begin
    eff = EW'(num_lists_r);
    if (eff == '0) begin
      eff = EW'(1);
    end else if (eff > EW'(MAX_LISTS)) begin
      eff = EW'(MAX_LISTS);
    end
  end

  assign lc_inc = EW'(load_cnt_r) + EW'(1);

  kwm_ram #(
    .WIDTH (DW + IW),
    .DEPTH (MAX_LISTS)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata_r)
  );

  kwm_cmp #(
    .DW (DW),
    .SW (IW)
  ) u_cmp (
    .a_val  (cmp_a_val),
    .a_src  (cmp_a_src),
    .b_val  (cmp_b_val),
    .b_src  (cmp_b_src),
    .a_lt_b (cmp_lt)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    load_cnt_nxt   = load_cnt_r;
    emit_nxt       = emit_r;
    hole_nxt       = hole_r;
    cur_val_nxt    = cur_val_r;
    cur_src_nxt    = cur_src_r;
    best_val_nxt   = best_val_r;
    best_src_nxt   = best_src_r;
    best_child_nxt = best_child_r;
    best_idx_nxt   = best_idx_r;
    top_val_nxt    = top_val_r;
    top_src_nxt    = top_src_r;
    out_valid_nxt  = out_valid_r;
    out_val_nxt    = out_val_r;
    out_src_nxt    = out_src_r;
    out_done_nxt   = out_done_r;

    ram_we    = 1'b0;
    ram_waddr = hole_r;
    ram_wdata = {cur_val_r, cur_src_r};
    ram_raddr = hole_r;

    cmp_a_val = cur_val_r;
    cmp_a_src = cur_src_r;
    cmp_b_val = rd_val;
    cmp_b_src = rd_src;

    dec_en    = 1'b0;
    dec_child = 1'b0;
    dec_val   = cur_val_r;
    dec_src   = cur_src_r;
    dec_idx   = hole_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!phase_r) begin
            // Loading: insert a non-empty head at the bottom and let it climb.
            if (!in_tuser && (count_r < CW'(MAX_LISTS))) begin
              cur_val_nxt = in_val;
              cur_src_nxt = load_cnt_r[IW-1:0];
              hole_nxt    = count_r[IW-1:0];
              count_nxt   = count_r + CW'(1);
              state_nxt   = ST_SU_RD;
            end else begin
              state_nxt = ST_FINISH;
            end
            if (lc_inc < eff) begin
              load_cnt_nxt = lc_inc[CW-1:0];
              emit_nxt     = 1'b0;
            end else begin
              load_cnt_nxt = '0;
              emit_nxt     = 1'b1;
            end
          end else begin
            emit_nxt = 1'b1;
            hole_nxt = '0;
            if (!in_tuser) begin
              // Refill: the new element replaces the root and sinks.
              cur_val_nxt = in_val;
              cur_src_nxt = top_src_r;
              state_nxt   = ST_SD_L;
            end else begin
              // Stream ended: the last entry moves to the root and sinks.
              count_nxt = cnt_dec;
              if (count_r == CW'(1)) begin
                state_nxt = ST_FINISH;
              end else begin
                ram_raddr = cnt_dec[IW-1:0];
                state_nxt = ST_RD_LAST;
              end
            end
          end
        end
      end

      ST_RD_LAST: begin
        cur_val_nxt = rd_val;
        cur_src_nxt = rd_src;
        state_nxt   = ST_SD_L;
      end

      ST_SU_RD: begin
        if (hole_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          ram_raddr = parent;
          state_nxt = ST_SU_CMP;
        end
      end

      ST_SU_CMP: begin
        if (cmp_lt) begin
          // Parent moves down into the hole.
          ram_we    = 1'b1;
          ram_wdata = ram_rdata_r;
          hole_nxt  = parent;
          state_nxt = ST_SU_RD;
        end else begin
          ram_we    = 1'b1;
          state_nxt = ST_FINISH;
        end
      end

      ST_SD_L: begin
        if (lchild >= cnt_x) begin
          ram_we    = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          ram_raddr = lchild[IW-1:0];
          state_nxt = ST_SD_R;
        end
      end

      ST_SD_R: begin
        cmp_a_val = rd_val;
        cmp_a_src = rd_src;
        cmp_b_val = cur_val_r;
        cmp_b_src = cur_src_r;
        if (cmp_lt) begin
          dec_child = 1'b1;
          dec_val   = rd_val;
          dec_src   = rd_src;
          dec_idx   = lchild[IW-1:0];
        end
        if (rchild < cnt_x) begin
          best_val_nxt   = dec_val;
          best_src_nxt   = dec_src;
          best_child_nxt = dec_child;
          best_idx_nxt   = dec_idx;
          ram_raddr      = rchild[IW-1:0];
          state_nxt      = ST_SD_CMP;
        end else begin
          dec_en = 1'b1;
        end
      end

      ST_SD_CMP: begin
        cmp_a_val = rd_val;
        cmp_a_src = rd_src;
        cmp_b_val = best_val_r;
        cmp_b_src = best_src_r;
        dec_en    = 1'b1;
        if (cmp_lt) begin
          dec_child = 1'b1;
          dec_val   = rd_val;
          dec_src   = rd_src;
          dec_idx   = rchild[IW-1:0];
        end else begin
          dec_child = best_child_r;
          dec_val   = best_val_r;
          dec_src   = best_src_r;
          dec_idx   = best_idx_r;
        end
      end

      ST_FINISH: begin
        if (!emit_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (count_r == '0) begin
            out_val_nxt  = '0;
            out_src_nxt  = '0;
            out_done_nxt = 1'b1;
            phase_nxt    = 1'b0;
            load_cnt_nxt = '0;
          end else begin
            out_val_nxt  = top_val_r;
            out_src_nxt  = top_src_wide[SRC_W-1:0];
            out_done_nxt = 1'b0;
            phase_nxt    = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Sift-down step: either the smaller child rises into the hole, or the
    // moving entry settles here.
    if (dec_en) begin
      ram_we = 1'b1;
      if (dec_child) begin
        ram_wdata = {dec_val, dec_src};
        hole_nxt  = dec_idx;
        state_nxt = ST_SD_L;
      end else begin
        state_nxt = ST_FINISH;
      end
    end

    // Keep the root copy in step with every write to the root slot.
    if (ram_we && (ram_waddr == '0)) begin
      top_val_nxt = ram_wdata[DW+IW-1:IW];
      top_src_nxt = ram_wdata[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      count_r     <= '0;
      load_cnt_r  <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      num_lists_r <= kwm_pkg::cfg_t'(1);
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      load_cnt_r  <= load_cnt_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        num_lists_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hole_r       <= hole_nxt;
    cur_val_r    <= cur_val_nxt;
    cur_src_r    <= cur_src_nxt;
    best_val_r   <= best_val_nxt;
    best_src_r   <= best_src_nxt;
    best_child_r <= best_child_nxt;
    best_idx_r   <= best_idx_nxt;
    top_val_r    <= top_val_nxt;
    top_src_r    <= top_src_nxt;
    out_val_r    <= out_val_nxt;
    out_src_r    <= out_src_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_src_r, out_val_r});
  assign out_tuser  = out_done_r;

`ifndef NO_ASSERTIONS
  // The heap never holds more entries than there are streams.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(MAX_LISTS))
    else $error("heap count above MAX_LISTS");

  // Between items in the merge phase the heap is never empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && phase_r) |-> count_r != '0)
    else $error("merge phase with an empty heap");

  // The load counter always stays below the stream limit.
  assert property (@(posedge clk) disable iff (!rst_n) load_cnt_r < CW'(MAX_LISTS))
    else $error("load counter out of range");

  // After an accepted item, in_tready drops while the sequencer works on it.
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_tready)
    else $error("input taken twice in a row");

  // A done result carries zero data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata == '0)
    else $error("done result with nonzero data");
`endif

endmodule : k_way_sorted_merge_unit

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the k-way sorted merge unit, with a heap-based merge predictor.
`timescale 1ns / 1ps

module tb;

  localparam int STREAMS       = 16;
  localparam int VAL_W         = 32;
  localparam int SRC_W         = kwm_pkg::SRC_FIELD_W;
  localparam int OUT_W         = ((VAL_W + SRC_W + 7) / 8) * 8;
  // Idle time after the owed results, so that any pending sift at 16 streams can finish.
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 600;
  // Past this many random transfers both sides stop idling.
  localparam int CALM_AFTER    = 500;
  localparam int MAX_REPORTS   = 100;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SRC_W-1:0] src;
    logic             done;
  } merged_t;

  // Tracks the merge as the block should see it: its own heap of stream heads,
  // the stream count register, and the queue of results still owed.
  class merge_checker;
    int      heap_val[STREAMS];
    int      heap_src[STREAMS];
    int      count;
    int      loaded;
    int      refill;
    bit      merging;
    int      lists_reg;
    merged_t expected_merged[$];
    int      errors;
    int      n_in;
    int      n_out;
    int      n_done;

    function new();
      count     = 0;
      loaded    = 0;
      refill    = 0;
      merging   = 1'b0;
      lists_reg = 1;
      errors    = 0;
      n_in      = 0;
      n_out     = 0;
      n_done    = 0;
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    function void set_lists(int v);
      lists_reg = v & 31;
    endfunction

    // A count of zero behaves as one stream; anything above the heap size is clipped.
    function int eff_lists();
      if (lists_reg < 1) return 1;
      if (lists_reg > STREAMS) return STREAMS;
      return lists_reg;
    endfunction

    // Ordering key is (signed value, stream index), so ties leave the lower stream first.
    function bit ranks_lower(int a, int b);
      if (heap_val[a] != heap_val[b]) return heap_val[a] < heap_val[b];
      return heap_src[a] < heap_src[b];
    endfunction

    function void swap_slots(int a, int b);
      int v;
      int s;
      v           = heap_val[a];
      s           = heap_src[a];
      heap_val[a] = heap_val[b];
      heap_src[a] = heap_src[b];
      heap_val[b] = v;
      heap_src[b] = s;
    endfunction

    function void climb(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!ranks_lower(i, p)) break;
        swap_slots(i, p);
        i = p;
      end
    endfunction

    function void sink(int i);
      int l;
      int m;
      forever begin
        l = 2 * i + 1;
        m = i;
        if (l < count && ranks_lower(l, m)) m = l;
        if (l + 1 < count && ranks_lower(l + 1, m)) m = l + 1;
        if (m == i) break;
        swap_slots(i, m);
        i = m;
      end
    endfunction

    // Called for every accepted input transfer; returns 1 when it owes a result.
    function bit accept_item(int value, bit ended);
      merged_t e;
      int      eff;
      n_in++;
      if (!merging) begin
        eff = eff_lists();
        if (!ended && count < STREAMS) begin
          heap_val[count] = value;
          heap_src[count] = loaded;
          count++;
          climb(count - 1);
        end
        loaded++;
        if (loaded < eff) return 1'b0;
        loaded = 0;
      end else if (count > 0) begin
        if (!ended) begin
          heap_val[0] = value;
          heap_src[0] = refill;
        end else begin
          count--;
          heap_val[0] = heap_val[count];
          heap_src[0] = heap_src[count];
        end
        sink(0);
      end
      if (count == 0) begin
        merging = 1'b0;
        loaded  = 0;
        refill  = 0;
        e.value = '0;
        e.src   = '0;
        e.done  = 1'b1;
      end else begin
        merging = 1'b1;
        refill  = heap_src[0];
        e.value = heap_val[0];
        e.src   = heap_src[0][SRC_W-1:0];
        e.done  = 1'b0;
      end
      expected_merged.push_back(e);
      return 1'b1;
    endfunction

    task compare_result(logic [OUT_W-1:0] tdata, logic tuser);
      merged_t e;
      n_out++;
      if (tuser) n_done++;
      if (expected_merged.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: tdata=%h tuser=%b", tdata, tuser));
        return;
      end
      e = expected_merged.pop_front();
      if (tdata[VAL_W-1:0] !== e.value)
        report_mismatch($sformatf("value_res %0d, wanted %0d",
                                  $signed(tdata[VAL_W-1:0]), $signed(e.value)));
      if (tdata[VAL_W +: SRC_W] !== e.src)
        report_mismatch($sformatf("source_list %0d, wanted %0d",
                                  tdata[VAL_W +: SRC_W], e.src));
      if (tuser !== e.done)
        report_mismatch($sformatf("done_res %b, wanted %b", tuser, e.done));
    endtask
  endclass

  // Every block input is known from time zero.
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  kwm_pkg::cfg_t          cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [VAL_W-1:0]       in_tdata    = '0;    // value
  logic                   in_tuser    = 1'b0;  // list_ended
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_W-1:0]       out_tdata;           // value_res, source_list, zero fill
  logic                   out_tuser;           // done_res

  merge_checker chk;
  // Pending elements of each stream for the merge that is running.
  int   stream_q[STREAMS][$];
  bit   calm      = 1'b0;
  int   in_odds   = 4;
  int   out_odds  = 4;
  int   merges    = 0;
  int   cfg_count = 0;

  k_way_sorted_merge_unit #(
    .MAX_LISTS  (STREAMS),
    .DATA_WIDTH (VAL_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver side: out_tready drops in short random bursts until the calm tail.
  // Each negedge makes exactly one assignment, so no update ordering matters.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && !calm && out_odds != 0 && $urandom_range(1, out_odds) == 1)
        hold = $urandom_range(1, 4);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.compare_result(out_tdata, out_tuser);
  end

  // Drives one input transfer, optionally after a short gap with tvalid low, and
  // tells the predictor once the transfer is taken at a rising edge.
  task automatic send_item(input int value, input bit ended, output bit produced);
    int gap;
    gap = 0;
    if (!calm && in_odds != 0 && $urandom_range(1, in_odds) == 1) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= ended;
    do @(posedge clk); while (!in_tready);
    produced = chk.accept_item(value, ended);
  endtask

  // Holds the sender off until every owed result has arrived, then lets the block
  // finish any internal work that produces no result (a head load, for example).
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (chk.expected_merged.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register is only written once the block has gone quiet.
  task automatic write_lists(input int v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= kwm_pkg::cfg_t'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    chk.set_lists(v);
    cfg_count++;
  endtask

  // An exhausted stream answers with list_ended and random don't-care data.
  task automatic next_element(input int s, output int v, output bit ended);
    if (stream_q[s].size() == 0) begin
      v     = $urandom;
      ended = 1'b1;
    end else begin
      v     = stream_q[s].pop_front();
      ended = 1'b0;
    end
  endtask

  // Builds n ascending streams. Some are empty, some are tightly clustered so
  // that heads tie across streams, some sit at the ends of the signed range, and
  // now and then one is left out of order.
  task automatic fill_streams(input int n);
    int vals[8];
    int len;
    int flavor;
    int t;
    int j;
    for (int s = 0; s < STREAMS; s++) stream_q[s].delete();
    for (int s = 0; s < n; s++) begin
      len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      flavor = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        case (flavor)
          0: vals[k] = $urandom;
          1: vals[k] = int'($urandom_range(0, 6)) - 3;
          2: begin
            case ($urandom_range(0, 3))
              0:       vals[k] = 32'h8000_0000;
              1:       vals[k] = 32'h8000_0001;
              2:       vals[k] = 32'h7fff_fffe;
              default: vals[k] = 32'h7fff_ffff;
            endcase
          end
          default: vals[k] = int'($urandom_range(0, 2000)) - 1000;
        endcase
      end
      for (int k = 1; k < len; k++) begin
        t = vals[k];
        j = k - 1;
        while (j >= 0 && vals[j] > t) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = t;
      end
      if (len > 1 && $urandom_range(0, 9) == 0) begin
        t             = vals[0];
        vals[0]       = vals[len - 1];
        vals[len - 1] = t;
      end
      for (int k = 0; k < len; k++) stream_q[s].push_back(vals[k]);
    end
  endtask

  // Runs one whole merge: heads for streams 0, 1, ... until loading completes,
  // then whatever stream the predictor says was just emitted, until done.
  // shrink_at rewrites the count in the middle of loading; pause_at holds the
  // sender off during merging and may rewrite the count for the next merge.
  task automatic run_merge(input int shrink_at, input int shrink_to,
                           input int pause_at, input int pause_cfg);
    int idx;
    int step;
    int v;
    bit ended;
    bit produced;
    idx  = 0;
    step = 0;
    do begin
      if (idx == shrink_at) write_lists(shrink_to);
      next_element(idx, v, ended);
      send_item(v, ended, produced);
      idx++;
    end while (!produced);
    while (chk.merging) begin
      if (step == pause_at && pause_cfg >= 0) begin
        write_lists(pause_cfg);
      end else if (step == pause_at || (!calm && $urandom_range(0, 39) == 0)) begin
        settle();
      end
      next_element(chk.refill, v, ended);
      send_item(v, ended, produced);
      step++;
    end
    merges++;
  endtask

  initial begin
    int directed_in;
    int nl;
    int eff;
    int shrink_at;
    int shrink_to;
    int pause_at;
    int pause_cfg;

    chk = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. First the reset count of one stream, carrying both ends
    // of the signed range.
    fill_streams(0);
    stream_q[0].push_back(32'h8000_0000);
    stream_q[0].push_back(32'h7fff_ffff);
    run_merge(-1, -1, -1, -1);

    // A count of zero acts as one stream; that stream is empty, so the only
    // head transfer yields done straight away.
    write_lists(0);
    fill_streams(0);
    run_merge(-1, -1, -1, -1);

    // Three streams, all empty: done when loading completes.
    write_lists(3);
    fill_streams(0);
    run_merge(-1, -1, -1, -1);

    // Count of four, cut to one after two heads, so the third head ends
    // loading. Streams 0 and 1 tie at 5; stream 2 goes down from -1 to -7.
    // Halfway through the merge the count is rewritten to two, which only
    // takes effect at the next loading phase.
    write_lists(4);
    fill_streams(0);
    stream_q[0].push_back(5);
    stream_q[1].push_back(5);
    stream_q[2].push_back(-1);
    stream_q[2].push_back(-7);
    run_merge(2, 1, 1, 2);

    // The count of two written above now governs loading.
    fill_streams(0);
    stream_q[0].push_back(0);
    stream_q[1].push_back(-1);
    run_merge(-1, -1, -1, -1);

    // Random part: whole merges with random stream contents, counts and idling.
    directed_in = chk.n_in;
    while (chk.n_in - directed_in < RANDOM_ITEMS) begin
      if (chk.n_in - directed_in > CALM_AFTER) calm = 1'b1;
      if (merges == 5) begin
        write_lists(16);
      end else if (merges == 6) begin
        write_lists(31);
      end else if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0, 1, 2: nl = $urandom_range(1, 5);
          3:       nl = $urandom_range(6, 16);
          default: nl = $urandom_range(0, 31);
        endcase
        write_lists(nl);
      end
      in_odds  = ($urandom_range(0, 2) == 0) ? 0 : 4;
      out_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
      eff = chk.eff_lists();
      fill_streams(eff);
      shrink_at = -1;
      shrink_to = -1;
      if (eff > 1 && $urandom_range(0, 9) == 0) begin
        shrink_at = $urandom_range(1, eff - 1);
        shrink_to = $urandom_range(0, shrink_at);
      end
      pause_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : -1;
      pause_cfg = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : -1;
      run_merge(shrink_at, shrink_to, pause_at, pause_cfg);
    end

    settle();

    $display("Ran %0d merges: %0d input and %0d result transfers, %0d of them done results.",
             merges, chk.n_in, chk.n_out, chk.n_done);
    $display("Stream count written %0d times, zero and out-of-range values included.",
             cfg_count);
    if (chk.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
